[hdl/rht_pkg.sv]
// Shared types, constants and helper functions for the refcounted handle table.
package rht_pkg;

	// Table geometry.
	localparam int HANDLE_ENTRIES  = 20;
	localparam int SLOT_ENTRIES    = 20;
	localparam int FIRST_FILE_SLOT = 4;

	localparam int HIDX_W = $clog2(HANDLE_ENTRIES);
	localparam int SIDX_W = $clog2(SLOT_ENTRIES);

	// Field types, fixed by the interface.
	typedef logic [4:0] handle_t;
	typedef logic [4:0] slot_t;
	typedef logic [1:0] kind_t;
	typedef logic [5:0] refs_t;
	typedef logic [1:0] status_t;
	typedef logic [2:0] cmd_t;

	// Handle and slot limits in field width.
	localparam handle_t H_CLOSED   = handle_t'(31);
	localparam handle_t HANDLE_CAP = handle_t'(HANDLE_ENTRIES);
	localparam slot_t   SLOT_CAP   = slot_t'(SLOT_ENTRIES);
	localparam slot_t   FIRST_SLOT = slot_t'(FIRST_FILE_SLOT);

	// Slot kinds.
	localparam kind_t K_FREE   = 2'd0;
	localparam kind_t K_FILE   = 2'd1;
	localparam kind_t K_DEVICE = 2'd2;

	localparam refs_t REFS_MAX = refs_t'(63);
	localparam refs_t REFS_ONE = refs_t'(1);

	// Result status codes.
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_INVALID = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
	localparam status_t ST_CORRUPT = 2'd3;

	// Command codes.
	localparam cmd_t CMD_LOOKUP = 3'd0;
	localparam cmd_t CMD_DUP    = 3'd1;
	localparam cmd_t CMD_DUP2   = 3'd2;
	localparam cmd_t CMD_OPEN   = 3'd3;
	localparam cmd_t CMD_CLOSE  = 3'd4;

	// Datapath micro-operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_RESOLVE,
		OP_SSCAN,
		OP_HSCAN,
		OP_BIND,
		OP_DST,
		OP_LINK,
		OP_CLOSE,
		OP_FIN
	} op_t;

	// Controller to datapath.
	typedef struct packed {
		op_t op;
	} ctl_t;

	// Datapath to controller.
	typedef struct packed {
		cmd_t cmd;
		logic fin;
		logic hit;
	} sts_t;

	// Clamp a limit write into [FIRST_FILE_SLOT, SLOT_ENTRIES].
	function automatic slot_t clamp_limit(slot_t v);
		slot_t x;
		x = v;
		if (x < FIRST_SLOT) x = FIRST_SLOT;
		if (x > SLOT_CAP) x = SLOT_CAP;
		return x;
	endfunction

	// Reset contents of the handle map.
	function automatic handle_t hm_reset(int i);
		handle_t v;
		case (i)
			0: v = handle_t'(0);
			1: v = handle_t'(1);
			2: v = handle_t'(1);
			3: v = handle_t'(2);
			4: v = handle_t'(3);
			default: v = H_CLOSED;
		endcase
		return v;
	endfunction

	// Reset kinds: the four standard device slots are in use.
	function automatic kind_t kd_reset(int i);
		return (i < 4) ? K_DEVICE : K_FREE;
	endfunction

	// Reset reference counts.
	function automatic refs_t ct_reset(int i);
		refs_t v;
		case (i)
			0: v = refs_t'(1);
			1: v = refs_t'(2);
			2: v = refs_t'(1);
			3: v = refs_t'(1);
			default: v = refs_t'(0);
		endcase
		return v;
	endfunction

endpackage

[hdl/rht_datapath.sv]
// Datapath of the handle table: table storage, scan counter and result registers.
module rht_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  rht_pkg::ctl_t       ctl,
	input  rht_pkg::cmd_t       cmd,
	input  rht_pkg::handle_t    src_handle,
	input  rht_pkg::handle_t    dst_handle,
	input  rht_pkg::kind_t      open_kind,
	input  logic                cfg_we,
	input  rht_pkg::slot_t      cfg_data,
	output rht_pkg::sts_t       sts,
	output logic                done,
	output rht_pkg::status_t    status,
	output rht_pkg::handle_t    new_handle,
	output rht_pkg::slot_t      slot_index,
	output rht_pkg::kind_t      slot_kind,
	output rht_pkg::refs_t      slot_refs
);

	// Table storage.
	rht_pkg::handle_t hm_q [rht_pkg::HANDLE_ENTRIES];
	rht_pkg::kind_t   kd_q [rht_pkg::SLOT_ENTRIES];
	rht_pkg::refs_t   ct_q [rht_pkg::SLOT_ENTRIES];
	rht_pkg::slot_t   limit_q;

	// Command registers.
	rht_pkg::cmd_t    cmd_q;
	rht_pkg::handle_t src_q;
	rht_pkg::handle_t dst_q;
	rht_pkg::kind_t   okind_q;
	rht_pkg::slot_t   s_q;
	rht_pkg::handle_t hnd_q;
	rht_pkg::handle_t i_q;
	rht_pkg::status_t st_q;
	logic             slot_ok_q;
	rht_pkg::handle_t nh_q;

	// Result registers.
	logic             done_q;
	rht_pkg::status_t status_q;
	rht_pkg::handle_t new_handle_q;
	rht_pkg::slot_t   slot_index_q;
	rht_pkg::kind_t   slot_kind_q;
	rht_pkg::refs_t   slot_refs_q;

	// Next values and write controls.
	rht_pkg::slot_t   s_d;
	rht_pkg::handle_t hnd_d;
	rht_pkg::handle_t i_d;
	rht_pkg::status_t st_d;
	logic             slot_ok_d;
	rht_pkg::handle_t nh_d;
	logic             fin;
	logic             hit;
	logic             h_we;
	rht_pkg::handle_t h_waddr;
	rht_pkg::handle_t h_wdata;
	logic             s_we;
	rht_pkg::slot_t   s_waddr;
	rht_pkg::kind_t   kd_wdata;
	rht_pkg::refs_t   ct_wdata;

	// Read ports.
	rht_pkg::handle_t h_raddr;
	rht_pkg::handle_t hm_rd;
	rht_pkg::slot_t   s_raddr;
	rht_pkg::kind_t   kd_rd;
	rht_pkg::refs_t   ct_rd;
	rht_pkg::refs_t   ct_inc;
	rht_pkg::refs_t   ct_dec;
	rht_pkg::kind_t   kd_dec;
	logic             slot_bad;
	rht_pkg::status_t res_st;

	// Handle map read address follows the running operation.
	always_comb begin
		case (ctl.op)
			rht_pkg::OP_DST:   h_raddr = dst_q;
			rht_pkg::OP_HSCAN: h_raddr = i_q;
			rht_pkg::OP_CLOSE: h_raddr = i_q;
			default:           h_raddr = src_q;
		endcase
	end

	// Out-of-range handles read as closed.
	assign hm_rd = (h_raddr < rht_pkg::HANDLE_CAP) ?
		hm_q[h_raddr[rht_pkg::HIDX_W-1:0]] : rht_pkg::H_CLOSED;

	// Slot read address: the mapped slot, the scan index or the held slot.
	always_comb begin
		case (ctl.op)
			rht_pkg::OP_RESOLVE: s_raddr = hm_rd;
			rht_pkg::OP_DST:     s_raddr = hm_rd;
			rht_pkg::OP_CLOSE:   s_raddr = hm_rd;
			rht_pkg::OP_SSCAN:   s_raddr = i_q;
			default:             s_raddr = s_q;
		endcase
	end

	// Out-of-range slots read as free and empty.
	assign kd_rd = (s_raddr < rht_pkg::SLOT_CAP) ?
		kd_q[s_raddr[rht_pkg::SIDX_W-1:0]] : rht_pkg::K_FREE;
	assign ct_rd = (s_raddr < rht_pkg::SLOT_CAP) ?
		ct_q[s_raddr[rht_pkg::SIDX_W-1:0]] : '0;

	// Saturating reference count update; the last release frees the slot.
	assign ct_inc = (ct_rd < rht_pkg::REFS_MAX) ? ct_rd + rht_pkg::REFS_ONE : ct_rd;
	assign ct_dec = (ct_rd != '0) ? ct_rd - rht_pkg::REFS_ONE : ct_rd;
	assign kd_dec = (ct_dec == '0) ? rht_pkg::K_FREE : kd_rd;

	// Resolution of the mapped slot.
	assign slot_bad = (hm_rd >= rht_pkg::SLOT_CAP) || (kd_rd == rht_pkg::K_FREE);
	assign res_st   = (hm_rd == rht_pkg::H_CLOSED) ? rht_pkg::ST_INVALID :
		slot_bad ? rht_pkg::ST_CORRUPT : rht_pkg::ST_OK;

	// Per-operation work.
	always_comb begin
		fin       = 1'b0;
		hit       = 1'b0;
		s_d       = s_q;
		hnd_d     = hnd_q;
		i_d       = i_q;
		st_d      = st_q;
		slot_ok_d = slot_ok_q;
		nh_d      = nh_q;
		h_we      = 1'b0;
		h_waddr   = i_q;
		h_wdata   = rht_pkg::H_CLOSED;
		s_we      = 1'b0;
		s_waddr   = s_raddr;
		kd_wdata  = kd_rd;
		ct_wdata  = ct_rd;
		case (ctl.op)
			rht_pkg::OP_LOAD: begin
				st_d      = rht_pkg::ST_INVALID;
				slot_ok_d = 1'b0;
				nh_d      = rht_pkg::H_CLOSED;
				i_d       = (cmd == rht_pkg::CMD_OPEN) ? rht_pkg::FIRST_SLOT : '0;
			end
			rht_pkg::OP_RESOLVE: begin
				s_d = hm_rd;
				if (res_st != rht_pkg::ST_OK) begin
					st_d = res_st;
					fin  = 1'b1;
				end else begin
					case (cmd_q)
						rht_pkg::CMD_LOOKUP: begin
							st_d      = rht_pkg::ST_OK;
							slot_ok_d = 1'b1;
							fin       = 1'b1;
						end
						rht_pkg::CMD_DUP: hit = 1'b1;
						rht_pkg::CMD_DUP2: begin
							if (dst_q >= rht_pkg::HANDLE_CAP) begin
								st_d = rht_pkg::ST_INVALID;
								fin  = 1'b1;
							end else if (src_q == dst_q) begin
								st_d      = rht_pkg::ST_OK;
								slot_ok_d = 1'b1;
								fin       = 1'b1;
							end else begin
								hit = 1'b1;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			rht_pkg::OP_SSCAN: begin
				if (i_q >= limit_q) begin
					st_d = rht_pkg::ST_FULL;
					fin  = 1'b1;
				end else if (kd_rd == rht_pkg::K_FREE) begin
					s_d = i_q;
					i_d = '0;
					hit = 1'b1;
				end else begin
					i_d = i_q + 5'd1;
				end
			end
			rht_pkg::OP_HSCAN: begin
				if (i_q >= rht_pkg::HANDLE_CAP) begin
					st_d = rht_pkg::ST_FULL;
					fin  = 1'b1;
				end else if (hm_rd == rht_pkg::H_CLOSED) begin
					hnd_d = i_q;
					hit   = 1'b1;
				end else begin
					i_d = i_q + 5'd1;
				end
			end
			rht_pkg::OP_BIND: begin
				h_we    = 1'b1;
				h_waddr = hnd_q;
				h_wdata = s_q;
				s_we    = 1'b1;
				if (cmd_q == rht_pkg::CMD_OPEN) begin
					kd_wdata = (okind_q == rht_pkg::K_DEVICE) ? rht_pkg::K_DEVICE :
						rht_pkg::K_FILE;
					ct_wdata = rht_pkg::REFS_ONE;
				end else begin
					ct_wdata = ct_inc;
				end
				st_d      = rht_pkg::ST_OK;
				slot_ok_d = 1'b1;
				nh_d      = hnd_q;
				fin       = 1'b1;
			end
			rht_pkg::OP_DST: begin
				if (hm_rd == rht_pkg::H_CLOSED) begin
					hit = 1'b1;
				end else if (slot_bad) begin
					st_d = rht_pkg::ST_CORRUPT;
					fin  = 1'b1;
				end else if (hm_rd == s_q) begin
					st_d      = rht_pkg::ST_OK;
					slot_ok_d = 1'b1;
					fin       = 1'b1;
				end else begin
					// Release the old target before relinking.
					s_we     = 1'b1;
					kd_wdata = kd_dec;
					ct_wdata = ct_dec;
					hit      = 1'b1;
				end
			end
			rht_pkg::OP_LINK: begin
				h_we      = 1'b1;
				h_waddr   = dst_q;
				h_wdata   = s_q;
				s_we      = 1'b1;
				ct_wdata  = ct_inc;
				st_d      = rht_pkg::ST_OK;
				slot_ok_d = 1'b1;
				fin       = 1'b1;
			end
			rht_pkg::OP_CLOSE: begin
				if (i_q >= rht_pkg::HANDLE_CAP) begin
					st_d = rht_pkg::ST_OK;
					fin  = 1'b1;
				end else if (hm_rd == rht_pkg::H_CLOSED) begin
					i_d = i_q + 5'd1;
				end else if (slot_bad) begin
					st_d = rht_pkg::ST_CORRUPT;
					fin  = 1'b1;
				end else if (hm_rd < rht_pkg::FIRST_SLOT) begin
					i_d = i_q + 5'd1;
				end else begin
					// Close a file handle and release its slot.
					s_we     = 1'b1;
					kd_wdata = kd_dec;
					ct_wdata = ct_dec;
					h_we     = 1'b1;
					i_d      = i_q + 5'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.cmd = cmd_q;
	assign sts.fin = fin;
	assign sts.hit = hit;

	// Table state and limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < rht_pkg::HANDLE_ENTRIES; k++) begin
				hm_q[k] <= rht_pkg::hm_reset(k);
			end
			for (int k = 0; k < rht_pkg::SLOT_ENTRIES; k++) begin
				kd_q[k] <= rht_pkg::kd_reset(k);
				ct_q[k] <= rht_pkg::ct_reset(k);
			end
			limit_q <= rht_pkg::clamp_limit(rht_pkg::slot_t'(20));
		end else begin
			if (h_we) begin
				hm_q[h_waddr[rht_pkg::HIDX_W-1:0]] <= h_wdata;
			end
			if (s_we) begin
				kd_q[s_waddr[rht_pkg::SIDX_W-1:0]] <= kd_wdata;
				ct_q[s_waddr[rht_pkg::SIDX_W-1:0]] <= ct_wdata;
			end
			if (cfg_we) begin
				limit_q <= rht_pkg::clamp_limit(cfg_data);
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctl.op == rht_pkg::OP_FIN);
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		if (ctl.op == rht_pkg::OP_LOAD) begin
			cmd_q   <= cmd;
			src_q   <= src_handle;
			dst_q   <= dst_handle;
			okind_q <= open_kind;
		end
		s_q       <= s_d;
		hnd_q     <= hnd_d;
		i_q       <= i_d;
		st_q      <= st_d;
		slot_ok_q <= slot_ok_d;
		nh_q      <= nh_d;
		if (ctl.op == rht_pkg::OP_FIN) begin
			status_q     <= st_q;
			new_handle_q <= nh_q;
			slot_index_q <= slot_ok_q ? s_q : '0;
			slot_kind_q  <= slot_ok_q ? kd_rd : rht_pkg::K_FREE;
			slot_refs_q  <= slot_ok_q ? ct_rd : '0;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign new_handle = new_handle_q;
	assign slot_index = slot_index_q;
	assign slot_kind  = slot_kind_q;
	assign slot_refs  = slot_refs_q;

	// A failed command never reports a slot or a handle.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != rht_pkg::ST_OK) |->
			(new_handle == rht_pkg::H_CLOSED) && (slot_index == '0) && (slot_refs == '0))
		else $error("error result carries slot data");

	// An issued handle is always one inside the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (new_handle != rht_pkg::H_CLOSED) |-> (new_handle < rht_pkg::HANDLE_CAP))
		else $error("new handle outside the table");

endmodule

[hdl/rht_controller.sv]
// Controller state machine of the handle table: sequences the datapath operations.
module rht_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rht_pkg::sts_t sts,
	output rht_pkg::ctl_t ctl,
	output logic          busy
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECODE = 10'b00_0000_0010,
		S_RES    = 10'b00_0000_0100,
		S_SSCAN  = 10'b00_0000_1000,
		S_HSCAN  = 10'b00_0001_0000,
		S_BIND   = 10'b00_0010_0000,
		S_DST    = 10'b00_0100_0000,
		S_LINK   = 10'b00_1000_0000,
		S_CLOSE  = 10'b01_0000_0000,
		S_FIN    = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and operation for the datapath.
	always_comb begin
		state_d = state_q;
		ctl.op  = rht_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op  = rht_pkg::OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.cmd)
					rht_pkg::CMD_LOOKUP: state_d = S_RES;
					rht_pkg::CMD_DUP:    state_d = S_RES;
					rht_pkg::CMD_DUP2:   state_d = S_RES;
					rht_pkg::CMD_OPEN:   state_d = S_SSCAN;
					rht_pkg::CMD_CLOSE:  state_d = S_CLOSE;
					default:             state_d = S_FIN;
				endcase
			end
			S_RES: begin
				ctl.op = rht_pkg::OP_RESOLVE;
				if (sts.fin) begin
					state_d = S_FIN;
				end else if (sts.cmd == rht_pkg::CMD_DUP) begin
					state_d = S_HSCAN;
				end else begin
					state_d = S_DST;
				end
			end
			S_SSCAN: begin
				ctl.op = rht_pkg::OP_SSCAN;
				if (sts.fin) begin
					state_d = S_FIN;
				end else if (sts.hit) begin
					state_d = S_HSCAN;
				end
			end
			S_HSCAN: begin
				ctl.op = rht_pkg::OP_HSCAN;
				if (sts.fin) begin
					state_d = S_FIN;
				end else if (sts.hit) begin
					state_d = S_BIND;
				end
			end
			S_BIND: begin
				ctl.op  = rht_pkg::OP_BIND;
				state_d = S_FIN;
			end
			S_DST: begin
				ctl.op  = rht_pkg::OP_DST;
				state_d = sts.fin ? S_FIN : S_LINK;
			end
			S_LINK: begin
				ctl.op  = rht_pkg::OP_LINK;
				state_d = S_FIN;
			end
			S_CLOSE: begin
				ctl.op = rht_pkg::OP_CLOSE;
				if (sts.fin) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				ctl.op  = rht_pkg::OP_FIN;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// A scan that neither ends nor hits stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOSE) && !sts.fin |=> (state_q == S_CLOSE))
		else $error("close scan left early");

	// Dup2 reaches the relink step only through the target check.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK) |-> ($past(state_q) == S_DST) && (sts.cmd == rht_pkg::CMD_DUP2))
		else $error("relink without target check");

endmodule

[hdl/refcounted_handle_table_unit.sv]
// Top level of the refcounted handle table: controller and datapath.
//
// A command beat is taken at a clock edge where start is high and busy is low, and
// exactly one result beat follows on done, high for a single cycle; the receiver
// cannot stall it and must take it in that cycle. Busy rises the cycle after start
// and falls in the cycle in which done is high, so a new command may be issued then.
// Commands run one at a time through a sequencer that visits one table entry per
// cycle: lookup resolves the source handle; dup2 resolves it, checks the target
// and, where needed, relinks it; dup resolves it and scans for the lowest closed
// handle; open scans the file slots for a free one, then scans for the lowest
// closed handle and binds it; close-process walks every handle in turn, or stops
// early on a corrupt entry. The handle scan and the slot scan each read one entry
// per cycle. A write to files_limit through cfg_we and cfg_data is registered and
// is clamped to the range of file slots.
module refcounted_handle_table_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rht_pkg::cmd_t       cmd,
	input  rht_pkg::handle_t    src_handle,
	input  rht_pkg::handle_t    dst_handle,
	input  rht_pkg::kind_t      open_kind,
	input  logic                cfg_we,
	input  rht_pkg::slot_t      cfg_data,
	output logic                done,
	output rht_pkg::status_t    status,
	output rht_pkg::handle_t    new_handle,
	output rht_pkg::slot_t      slot_index,
	output rht_pkg::kind_t      slot_kind,
	output rht_pkg::refs_t      slot_refs
);

	rht_pkg::ctl_t ctl;
	rht_pkg::sts_t sts;

	// Sequencer.
	rht_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// Table storage and result registers.
	rht_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cmd        (cmd),
		.src_handle (src_handle),
		.dst_handle (dst_handle),
		.open_kind  (open_kind),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.sts        (sts),
		.done       (done),
		.status     (status),
		.new_handle (new_handle),
		.slot_index (slot_index),
		.slot_kind  (slot_kind),
		.slot_refs  (slot_refs)
	);

	// An accepted command keeps the block busy until its result.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command accepted without going busy");

	// The result beat comes out only while the block is ready again.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && !$past(done))
		else $error("result beat overlaps a busy cycle");

endmodule
